[design/jse_pkg.sv]
// Shared constants and helpers for the JS string escaper.
// Character codes used by the escape logic and a nibble-to-hex function.
// No dependencies.
package jse_pkg;

    localparam int unsigned MaxRun = 8;

    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_LOWER_B = 8'h62;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CH_LOWER_R = 8'h72;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_LOWER_U = 8'h75;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_TWO     = 8'h32;
    localparam logic [7:0] CH_EIGHT   = 8'h38;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;

    // UTF-8 lead and continuation bytes of U+2028 / U+2029
    localparam logic [7:0] UTF_LEAD   = 8'hE2;
    localparam logic [7:0] UTF_MID    = 8'h80;
    localparam logic [7:0] UTF_LS     = 8'hA8;
    localparam logic [7:0] UTF_PS     = 8'hA9;

    typedef logic [7:0] byte_t;

    function automatic byte_t hex_digit(input logic [3:0] v);
        byte_t d;
        if (v < 4'd10)
        begin
            d = CH_ZERO + {4'd0, v};
        end
        else
        begin
            d = CH_UPPER_A + {4'd0, v - 4'd10};
        end
        return d;
    endfunction

endpackage

[design/js_string_escaper.sv]
// JS string escaper: accepts one raw byte per beat, emits 0 to 8 escaped bytes.
// Latency: results of a byte are registered and appear in the cycle after it is accepted.
// Throughput: one input beat per cycle while each byte expands to a single
// output byte and out_stall is low; a byte that emits more bytes stalls input
// until its run drains through the one-byte-per-cycle output run buffer.
// Reset (rst_n, async, active low): no held prefix, run buffer empty.
module js_string_escaper
    import jse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       string_last
);

    typedef enum logic [1:0]
    {
        HELD_NONE  = 2'd0,
        HELD_E2    = 2'd1,
        HELD_E2_80 = 2'd2
    } held_t;

    held_t       held_reg, held_next;
    logic        run_valid_reg, run_valid_next;
    logic [2:0]  idx_reg, idx_next;
    logic [2:0]  last_idx_reg;
    logic        str_last_reg;
    byte_t       run_byte_reg [MaxRun];

    logic        out_take, run_done, in_take;

    byte_t       plain_b [6];
    logic [2:0]  plain_n;
    byte_t       tail_b  [MaxRun];
    logic [2:0]  tail_n;
    logic [1:0]  pre_n;
    logic        fresh;
    byte_t       exp_b   [MaxRun];
    logic [3:0]  exp_n;
    held_t       held_new;

    // Output side: the run buffer drives the port directly
    assign out_valid   = run_valid_reg;
    assign out_byte    = run_byte_reg[idx_reg];
    assign run_last    = (idx_reg == last_idx_reg);
    assign string_last = run_last && str_last_reg;

    assign out_take = run_valid_reg && !out_stall;
    assign run_done = out_take && run_last;
    assign in_stall = run_valid_reg && !run_done;
    assign in_take  = in_valid && !in_stall;

    // Escape of one byte on its own
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            plain_b[i] = '0;
        end
        plain_n    = 3'd2;
        plain_b[0] = CH_BSLASH;
        priority if (in_byte == CH_BSLASH)
        begin
            plain_b[1] = CH_BSLASH;
        end
        else if (in_byte == CH_DQUOTE)
        begin
            plain_b[1] = CH_DQUOTE;
        end
        else if (in_byte == CH_BS)
        begin
            plain_b[1] = CH_LOWER_B;
        end
        else if (in_byte == CH_FF)
        begin
            plain_b[1] = CH_LOWER_F;
        end
        else if (in_byte == CH_LF)
        begin
            plain_b[1] = CH_LOWER_N;
        end
        else if (in_byte == CH_CR)
        begin
            plain_b[1] = CH_LOWER_R;
        end
        else if (in_byte == CH_TAB)
        begin
            plain_b[1] = CH_LOWER_T;
        end
        else if (in_byte < CH_SPACE)
        begin
            plain_n    = 3'd6;
            plain_b[1] = CH_LOWER_U;
            plain_b[2] = CH_ZERO;
            plain_b[3] = CH_ZERO;
            plain_b[4] = hex_digit(in_byte[7:4]);
            plain_b[5] = hex_digit(in_byte[3:0]);
        end
        else
        begin
            plain_n    = 3'd1;
            plain_b[0] = in_byte;
        end
    end

    // Prefix handling and assembly of the whole run
    always_comb
    begin
        pre_n    = 2'd0;
        fresh    = 1'b1;
        held_new = HELD_NONE;
        for (int i = 0; i < MaxRun; i++)
        begin
            tail_b[i] = '0;
        end
        tail_n = 3'd0;

        unique case (held_reg)
            HELD_E2:
            begin
                if (in_byte == UTF_MID && !in_last)
                begin
                    fresh    = 1'b0;
                    held_new = HELD_E2_80;
                end
                else
                begin
                    pre_n = 2'd1;
                end
            end
            HELD_E2_80:
            begin
                if (in_byte == UTF_LS || in_byte == UTF_PS)
                begin
                    fresh     = 1'b0;
                    tail_n    = 3'd6;
                    tail_b[0] = CH_BSLASH;
                    tail_b[1] = CH_LOWER_U;
                    tail_b[2] = CH_TWO;
                    tail_b[3] = CH_ZERO;
                    tail_b[4] = CH_TWO;
                    tail_b[5] = (in_byte == UTF_LS) ? CH_EIGHT : CH_NINE;
                end
                else
                begin
                    pre_n = 2'd2;
                end
            end
            default:
            begin
                pre_n = 2'd0;
            end
        endcase

        if (fresh)
        begin
            if (in_byte == UTF_LEAD && !in_last)
            begin
                held_new = HELD_E2;
            end
            else
            begin
                tail_n = plain_n;
                for (int i = 0; i < 6; i++)
                begin
                    tail_b[i] = plain_b[i];
                end
            end
        end

        // Shift the tail behind the flushed prefix bytes
        for (int i = 0; i < MaxRun; i++)
        begin
            exp_b[i] = tail_b[i];
        end
        if (pre_n == 2'd1)
        begin
            exp_b[0] = UTF_LEAD;
            for (int i = 1; i < MaxRun; i++)
            begin
                exp_b[i] = tail_b[i-1];
            end
        end
        else if (pre_n == 2'd2)
        begin
            exp_b[0] = UTF_LEAD;
            exp_b[1] = UTF_MID;
            for (int i = 2; i < MaxRun; i++)
            begin
                exp_b[i] = tail_b[i-2];
            end
        end
        exp_n = {2'd0, pre_n} + {1'b0, tail_n};
    end

    // Control next state
    always_comb
    begin
        held_next      = held_reg;
        run_valid_next = run_valid_reg;
        idx_next       = idx_reg;
        if (in_take)
        begin
            held_next      = held_new;
            run_valid_next = (exp_n != 4'd0);
            idx_next       = 3'd0;
        end
        else if (out_take)
        begin
            if (run_last)
            begin
                run_valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= HELD_NONE;
            run_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end
        else
        begin
            held_reg      <= held_next;
            run_valid_reg <= run_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // Load the run payload on every accepted beat
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            for (int i = 0; i < MaxRun; i++)
            begin
                run_byte_reg[i] <= exp_b[i];
            end
            last_idx_reg <= 3'(exp_n - 4'd1);
            str_last_reg <= in_last;
        end
    end

    // A final byte always leaves the prefix empty and produces output
    a_last_clears_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && in_last |=> held_reg == HELD_NONE)
        else $error("held prefix survives end of string");

    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && in_last |=> out_valid && str_last_reg)
        else $error("final byte produced no output run");

    a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> idx_reg <= last_idx_reg)
        else $error("run index beyond end of run");

    a_plain_emits: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && held_reg == HELD_NONE && in_byte != UTF_LEAD |=> out_valid)
        else $error("plain byte produced no output");

endmodule
